// ===== rtl/cpm_pkg.sv =====
// shared types and constants for the capped polynomial multiplier
package cpm_pkg;

    localparam int MAX_OPERAND_DEGREE = 15;
    localparam int COEFF_WIDTH        = 32;
    localparam int STORE_DEPTH        = MAX_OPERAND_DEGREE + 1;
    localparam int ACC_DEPTH          = 2 * MAX_OPERAND_DEGREE + 1;
    localparam int IDX_W              = $clog2(STORE_DEPTH);
    localparam int OUT_IDX_W          = $clog2(ACC_DEPTH);
    localparam int OP_W               = 2;
    localparam int CAP_W              = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(20);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A   = 2'd0,
        OP_LOAD_B   = 2'd1,
        OP_MULTIPLY = 2'd2,
        OP_UNUSED   = 2'd3
    } cpm_op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } cpm_state_t;

    typedef struct packed {
        logic [OP_W-1:0]               operation;
        logic [IDX_W-1:0]              coeff_index;
        logic signed [COEFF_WIDTH-1:0] coeff_value;
        logic [IDX_W-1:0]              degree_a;
        logic [IDX_W-1:0]              degree_b;
    } cpm_in_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]          out_index;
        logic signed [COEFF_WIDTH-1:0] out_value;
        logic                          last;
    } cpm_out_t;

    typedef struct packed {
        logic                   clear;
        logic                   advance;
        logic                   load_a;
        logic [IDX_W-1:0]       load_index;
        logic [IDX_W-1:0]       degree_a;
        logic                   cap_mode;
        logic [COEFF_WIDTH-1:0] x;
    } cpm_chain_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic advance;
        logic active;
    } cpm_cell_ctrl_t;

endpackage

// ===== rtl/cpm_cell.sv =====
// one tap of the transposed convolution chain: operand a coefficient and partial sum
module cpm_cell
    import cpm_pkg::*;
(
    input  logic                   clk,
    input  cpm_cell_ctrl_t         ctrl,
    input  logic [COEFF_WIDTH-1:0] coeff,
    input  logic [COEFF_WIDTH-1:0] x,
    input  logic [COEFF_WIDTH-1:0] acc_in,
    output logic [COEFF_WIDTH-1:0] acc_out
);

    logic [COEFF_WIDTH-1:0] a_reg;
    logic [COEFF_WIDTH-1:0] acc_reg;
    logic [COEFF_WIDTH-1:0] prod;
    logic [COEFF_WIDTH-1:0] acc_next;

    always_comb
    begin
        prod = ctrl.active ? a_reg * x : '0;
        acc_next = acc_in + prod;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= coeff;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

// ===== rtl/cpm_ctrl.sv =====
// sequencer: operand b store, cap register, feed counter and output control
module cpm_ctrl
    import cpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cpm_in_t              in_data,
    input  logic                 out_stall,
    input  logic                 cfg_write,
    input  logic [CAP_W-1:0]     cfg_data,
    output cpm_chain_t           chain,
    output logic                 out_valid,
    output logic [OUT_IDX_W-1:0] out_index,
    output logic                 out_last,
    output logic                 cap_mode
);

    cpm_state_t             state_reg, state_next;
    logic [OUT_IDX_W-1:0]   t_reg, t_next;
    logic [OUT_IDX_W-1:0]   end_reg, end_next;
    logic [IDX_W-1:0]       da_reg, da_next;
    logic [IDX_W-1:0]       db_reg, db_next;
    logic                   cap_mode_reg, cap_mode_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0]   idx_reg, idx_next;
    logic                   last_reg, last_next;
    logic [CAP_W-1:0]       cap_reg;
    logic [COEFF_WIDTH-1:0] b_store [STORE_DEPTH];

    logic                   accept;
    logic                   mul_accept;
    logic                   advance;
    logic                   feed;
    logic [OUT_IDX_W-1:0]   sum_deg;
    logic                   over_cap;
    logic [COEFF_WIDTH-1:0] x;

    assign accept     = in_valid && !in_stall;
    assign mul_accept = accept && (in_data.operation == OP_MULTIPLY);
    assign advance    = !out_valid_reg || !out_stall;
    assign feed       = (state_reg == ST_RUN) && advance;
    assign sum_deg    = OUT_IDX_W'(in_data.degree_a) + OUT_IDX_W'(in_data.degree_b);
    assign over_cap   = OUT_IDX_W'(sum_deg) > OUT_IDX_W'(cap_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (mul_accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (feed && (t_reg == end_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE: in_stall = out_valid_reg;
            ST_RUN:  in_stall = 1'b1;
            default: in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        x = '0;
        if (!cap_mode_reg && (t_reg <= OUT_IDX_W'(db_reg)))
        begin
            x = b_store[t_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        t_next         = t_reg;
        end_next       = end_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        cap_mode_next  = cap_mode_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = feed;
        end
        if (mul_accept)
        begin
            t_next        = '0;
            da_next       = in_data.degree_a;
            db_next       = in_data.degree_b;
            cap_mode_next = over_cap;
            end_next      = over_cap ? OUT_IDX_W'(cap_reg) : sum_deg;
        end
        if (feed)
        begin
            idx_next  = t_reg;
            last_next = (t_reg == end_reg);
            t_next    = t_reg + OUT_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            t_reg         <= '0;
            end_reg       <= '0;
            da_reg        <= '0;
            db_reg        <= '0;
            cap_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            cap_reg       <= CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            end_reg       <= end_next;
            da_reg        <= da_next;
            db_reg        <= db_next;
            cap_mode_reg  <= cap_mode_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (in_data.operation == OP_LOAD_B))
        begin
            b_store[in_data.coeff_index] <= in_data.coeff_value;
        end
    end

    always_comb
    begin
        chain.clear      = mul_accept;
        chain.advance    = feed;
        chain.load_a     = accept && (in_data.operation == OP_LOAD_A);
        chain.load_index = in_data.coeff_index;
        chain.degree_a   = da_reg;
        chain.cap_mode   = cap_mode_reg;
        chain.x          = x;
    end

    assign out_valid = out_valid_reg;
    assign out_index = idx_reg;
    assign out_last  = last_reg;
    assign cap_mode  = cap_mode_reg;

`ifndef SYNTH
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (state_reg == ST_IDLE))
        else $error("last coefficient shown while sequencer still running");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (idx_reg <= end_reg))
        else $error("output index beyond product degree");

    a_multiply_starts: assert property (@(posedge clk) disable iff (!rst_n)
        mul_accept |=> ((state_reg == ST_RUN) && (t_reg == '0)))
        else $error("multiply did not start the feed counter");

    a_not_last_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !last_reg) |=> out_valid_reg)
        else $error("sequencer stopped before last coefficient");
`endif

endmodule

// ===== rtl/capped_polynomial_multiply.sv =====
// top level of the capped polynomial multiplier: sequencer and cell chain
//
// input channel: in_valid / in_stall with in_data. a load A or load B
// transaction writes one coefficient; a multiply transaction uses
// degree_a and degree_b.
// output channel: out_valid / out_stall with out_data, one transaction per
// product coefficient, ascending index, last set on the highest one.
// a multiply whose degree sum is over the cap yields n^cap instead.
// degree_cap is written through cfg_write / cfg_data; the user must do so
// only while idle, as the block itself does not enforce it. a multiply
// moves the sequencer into its run state, and each feed step registers one
// coefficient at the output, one per cycle while the receiver does not stall.
// the chain of 16 cells holds operand A and the running partial sums;
// cell 0 holds the output coefficient while the receiver stalls, and the
// whole chain freezes with it. input is stalled during a multiply and
// while a result waits.
// reset returns the cap to 20 and empties the output; operand stores keep
// no defined value until loaded.
module capped_polynomial_multiply
    import cpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  cpm_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output cpm_out_t         out_data,
    input  logic             cfg_write,
    input  logic [CAP_W-1:0] cfg_data
);

    cpm_chain_t             chain;
    logic [OUT_IDX_W-1:0]   out_index;
    logic                   out_last;
    logic                   cap_mode;
    logic [COEFF_WIDTH-1:0] acc [STORE_DEPTH+1];

    cpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .chain     (chain),
        .out_valid (out_valid),
        .out_index (out_index),
        .out_last  (out_last),
        .cap_mode  (cap_mode)
    );

    assign acc[STORE_DEPTH] = '0;

    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        cpm_cell_ctrl_t cell_ctrl;

        always_comb
        begin
            cell_ctrl.load    = chain.load_a && (chain.load_index == IDX_W'(i));
            cell_ctrl.clear   = chain.clear;
            cell_ctrl.advance = chain.advance;
            cell_ctrl.active  = !chain.cap_mode && (IDX_W'(i) <= chain.degree_a);
        end

        cpm_cell u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl),
            .coeff   (in_data.coeff_value),
            .x       (chain.x),
            .acc_in  (acc[i+1]),
            .acc_out (acc[i])
        );
    end

    always_comb
    begin
        out_data.out_index = out_index;
        out_data.last      = out_last;
        if (cap_mode)
        begin
            out_data.out_value = {{(COEFF_WIDTH-1){1'b0}}, out_last};
        end
        else
        begin
            out_data.out_value = acc[0];
        end
    end

endmodule
